// File: hdl/elbow_assist_current_setpoint_core_macros.svh
// Assertion macros shared by the elbow assist setpoint RTL.
`ifndef ELBOW_ASSIST_CURRENT_SETPOINT_CORE_MACROS_SVH
`define ELBOW_ASSIST_CURRENT_SETPOINT_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define EACS_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define EACS_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/eacs_pkg.sv
// Types, constants and tables of the elbow assist current setpoint block.
package eacs_pkg;

  // Input transaction fields
  typedef struct packed {
    logic        [15:0] load_weight;
    logic signed [15:0] elbow_angle;
    logic        [15:0] assist_share;
  } in_item_t;

  // Result transaction fields
  typedef struct packed {
    logic [19:0] elbow_torque;
    logic [25:0] cable_force;
    logic [19:0] spool_torque;
    logic [15:0] motor_current;
  } out_item_t;

  // Configuration register file
  typedef struct packed {
    logic [15:0] hand_radius;
    logic [15:0] elbow_moment_arm;
    logic [15:0] spool_radius;
    logic [15:0] drive_efficiency;
    logic [15:0] torque_constant;
    logic [19:0] continuous_torque_limit;
    logic [15:0] continuous_current_limit;
    logic [15:0] stall_current_limit;
  } cfg_t;

  // Classified job handed from front to back
  typedef struct packed {
    logic        [15:0] load_weight;
    logic        [15:0] assist_share;   // clamped to one
    logic signed [31:0] angle;          // Q2.29, folded into [-pi/2, pi/2]
  } job_t;

  typedef enum logic [2:0] {
    CFG_HAND_RADIUS   = 3'd0,
    CFG_ELBOW_ARM     = 3'd1,
    CFG_SPOOL_RADIUS  = 3'd2,
    CFG_DRIVE_EFF     = 3'd3,
    CFG_TORQUE_CONST  = 3'd4,
    CFG_CONT_TORQUE   = 3'd5,
    CFG_CONT_CURRENT  = 3'd6,
    CFG_STALL_CURRENT = 3'd7
  } cfg_idx_e;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // Register reset values
  localparam logic [15:0] RST_HAND_RADIUS   = 16'd16384;
  localparam logic [15:0] RST_ELBOW_ARM     = 16'd2294;
  localparam logic [15:0] RST_SPOOL_RADIUS  = 16'd1809;
  localparam logic [15:0] RST_DRIVE_EFF     = 16'd26214;
  localparam logic [15:0] RST_TORQUE_CONST  = 16'd2840;
  localparam logic [19:0] RST_CONT_TORQUE   = 20'd376;
  localparam logic [15:0] RST_CONT_CURRENT  = 16'd640;
  localparam logic [15:0] RST_STALL_CURRENT = 16'd1280;

  // Physical constants and floors
  localparam logic [19:0] GRAVITY_Q16 = 20'd642690;
  localparam logic [15:0] ARM_FLOOR   = 16'd655;
  localparam logic [15:0] EFF_FLOOR   = 16'd3277;
  localparam logic [15:0] SHARE_ONE   = 16'd32768;

  // Angle constants, Q29
  localparam logic signed [33:0] PI_Q29      = 34'sd1686629713;
  localparam logic signed [33:0] TWO_PI_Q29  = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q29 = 34'sd843314856;

  // CORDIC gain and sine bound, Q30
  localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;
  localparam logic signed [32:0] ONE_Q30         = 33'sd1073741824;

  // Shared divider geometry
  localparam int DIV_NUM_W = 60;
  localparam int DIV_DEN_W = 20;

  // arctan(2^-i) in Q2.29
  function automatic logic [31:0] atan_q29(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:    r = 32'd421657428;
      5'd1:    r = 32'd248918915;
      5'd2:    r = 32'd131521918;
      5'd3:    r = 32'd66762579;
      5'd4:    r = 32'd33510843;
      5'd5:    r = 32'd16771758;
      5'd6:    r = 32'd8387925;
      5'd7:    r = 32'd4194219;
      5'd8:    r = 32'd2097141;
      5'd9:    r = 32'd1048575;
      5'd10:   r = 32'd524288;
      5'd11:   r = 32'd262144;
      5'd12:   r = 32'd131072;
      5'd13:   r = 32'd65536;
      5'd14:   r = 32'd32768;
      5'd15:   r = 32'd16384;
      5'd16:   r = 32'd8192;
      5'd17:   r = 32'd4096;
      5'd18:   r = 32'd2048;
      5'd19:   r = 32'd1024;
      5'd20:   r = 32'd512;
      5'd21:   r = 32'd256;
      5'd22:   r = 32'd128;
      5'd23:   r = 32'd64;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/eacs_front.sv
// Front end: takes input transactions, clamps and folds them, and queues jobs.
`include "elbow_assist_current_setpoint_core_macros.svh"

module eacs_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  eacs_pkg::in_item_t in_data_i,
  output logic               q_valid_o,
  input  logic               q_pop_i,
  output eacs_pkg::job_t     q_item_o
);

  eacs_pkg::job_t     job;
  logic signed [33:0] z;
  eacs_pkg::job_t     mem_q [2];
  logic               wr_ptr_q, rd_ptr_q;
  logic [1:0]         cnt_q;
  logic               push, pop;

  // Classify: clamp share, wrap angle by 2*pi, fold into the right half plane
  always_comb begin
    z = {{2{in_data_i.elbow_angle[15]}}, in_data_i.elbow_angle, 16'h0000};
    if (z > eacs_pkg::PI_Q29) z = z - eacs_pkg::TWO_PI_Q29;
    if (z < -eacs_pkg::PI_Q29) z = z + eacs_pkg::TWO_PI_Q29;
    if (z > eacs_pkg::HALF_PI_Q29) z = eacs_pkg::PI_Q29 - z;
    if (z < -eacs_pkg::HALF_PI_Q29) z = -eacs_pkg::PI_Q29 - z;
    job.load_weight  = in_data_i.load_weight;
    job.assist_share = (in_data_i.assist_share > eacs_pkg::SHARE_ONE) ?
                       eacs_pkg::SHARE_ONE : in_data_i.assist_share;
    job.angle        = 32'(z);
  end

  // Two-entry job queue
  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= job;
  end

  `EACS_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= 2'd2, "queue count overflow")
  `EACS_ASSERT_NXT(a_cnt_up, clk_i, rst_ni, push && !pop, cnt_q == $past(cnt_q) + 2'd1, "push lost")
  `EACS_ASSERT_IMP(a_share_ok, clk_i, rst_ni, q_valid_o, q_item_o.assist_share <= eacs_pkg::SHARE_ONE, "share not clamped")

endmodule

// File: hdl/eacs_div.sv
// Shared restoring divider, one quotient bit per cycle.
module eacs_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           go_i,
  input  logic [eacs_pkg::DIV_NUM_W-1:0] num_i,
  input  logic [eacs_pkg::DIV_DEN_W-1:0] den_i,
  output logic                           busy_o,
  output logic [eacs_pkg::DIV_NUM_W-1:0] quo_o
);

  localparam int NW = eacs_pkg::DIV_NUM_W;
  localparam int DW = eacs_pkg::DIV_DEN_W;
  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt_q;
  logic [NW-1:0] quo_q, quo_d;
  logic [DW-1:0] rem_q, rem_d, den_q;
  logic [DW:0]   trial;
  logic          ge;

  // One step: shift in next numerator bit, subtract if it fits
  always_comb begin
    trial = {rem_q, quo_q[NW-1]};
    ge    = (trial >= {1'b0, den_q});
    rem_d = ge ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
    quo_d = {quo_q[NW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (go_i) begin
      cnt_q <= CW'(NW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = quo_q;

endmodule

// File: hdl/eacs_back.sv
// Back end: CORDIC sine, multiply chain, divisions, limits and result register.
`include "elbow_assist_current_setpoint_core_macros.svh"

module eacs_back #(
  parameter int SINE_STAGES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  eacs_pkg::job_t      q_item_i,
  output logic                q_pop_o,
  input  eacs_pkg::cfg_t      cfg_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output eacs_pkg::out_item_t out_data_o
);

  localparam int CNT_W = (SINE_STAGES > 1) ? $clog2(SINE_STAGES) : 1;
  localparam int NW    = eacs_pkg::DIV_NUM_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CORDIC, ST_MUL_WG, ST_MUL_P, ST_MUL_PS, ST_MUL_T,
    ST_F_GO, ST_F_WAIT, ST_MUL_FS, ST_S_GO, ST_S_WAIT,
    ST_C_DEC, ST_C_GO, ST_C_WAIT, ST_OUT
  } state_e;

  state_e              st_q;
  logic [CNT_W-1:0]    cnt_q;
  logic signed [32:0]  x_q, y_q;
  logic signed [31:0]  z_q;
  logic [15:0]         w_q, a_q;
  logic [51:0]         acc_q;
  logic [36:0]         t_q;
  logic [42:0]         f_q;
  logic [47:0]         sp_q;
  logic [NW-1:0]       cur_q;
  logic                lim_q;
  logic                out_valid_q;
  eacs_pkg::out_item_t out_q;

  logic [15:0]         rho, eff, kt;
  logic signed [32:0]  dx, dy;
  logic signed [31:0]  at;
  logic [30:0]         sine;
  logic [35:0]         prod_wg;
  logic [51:0]         prod_p;
  logic [62:0]         prod_s;
  logic [52:0]         prod_t;
  logic [58:0]         prod_f;
  logic                div_go, div_busy;
  logic [NW-1:0]       div_num, div_quo;
  logic [eacs_pkg::DIV_DEN_W-1:0] div_den;
  logic                lim_now;
  logic [20:0]         et_w;
  logic [26:0]         cf_w;
  logic [47:0]         sp_sel;
  logic [32:0]         sp_w;
  logic [15:0]         cur_cap;
  eacs_pkg::out_item_t res;
  logic                load_out;

  // Floored moment arm and efficiency; the torque constant is passed through
  assign rho = (cfg_i.elbow_moment_arm > eacs_pkg::ARM_FLOOR) ?
               cfg_i.elbow_moment_arm : eacs_pkg::ARM_FLOOR;
  assign eff = (cfg_i.drive_efficiency > eacs_pkg::EFF_FLOOR) ?
               cfg_i.drive_efficiency : eacs_pkg::EFF_FLOOR;
  assign kt  = cfg_i.torque_constant;

  // CORDIC micro-rotation terms
  assign dx = y_q >>> cnt_q;
  assign dy = x_q >>> cnt_q;
  assign at = signed'(eacs_pkg::atan_q29(5'(cnt_q)));

  // Sine clamped to [0, one]
  always_comb begin
    if (y_q[32] || (y_q == 33'sd0)) sine = '0;
    else if (y_q > eacs_pkg::ONE_Q30) sine = 31'(eacs_pkg::ONE_Q30);
    else sine = y_q[30:0];
  end

  // Multiplier datapath, one product per state
  assign prod_wg = w_q * eacs_pkg::GRAVITY_Q16;
  assign prod_p  = acc_q[35:0] * cfg_i.hand_radius;
  assign prod_s  = acc_q[31:0] * sine;
  assign prod_t  = acc_q[36:0] * a_q;
  assign prod_f  = f_q * cfg_i.spool_radius;

  // Torque-limit decision on the unlimited spool torque
  assign lim_now = (sp_q > {cfg_i.continuous_torque_limit, 16'h0000});

  // Divider operand selection
  always_comb begin
    div_go  = 1'b0;
    div_num = '0;
    div_den = '0;
    case (st_q)
      ST_F_GO: begin
        div_go  = 1'b1;
        div_num = NW'({t_q, 16'h0000}) + NW'(rho >> 1);
        div_den = 20'(rho);
      end
      ST_S_GO: begin
        div_go  = 1'b1;
        div_num = NW'({acc_q[42:0], 15'h0000}) + NW'(eff >> 1);
        div_den = 20'(eff);
      end
      ST_C_GO: begin
        div_go = 1'b1;
        if (lim_q) begin
          div_num = NW'({cfg_i.continuous_torque_limit, 12'h000}) + NW'(kt >> 1);
          div_den = 20'(kt);
        end else begin
          div_num = NW'(sp_q) + NW'({kt, 3'b000});
          div_den = {kt, 4'b0000};
        end
      end
      default: ;
    endcase
  end

  eacs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (div_go),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .quo_o  (div_quo)
  );

  // Output rounding and saturation
  always_comb begin
    et_w    = 21'((t_q + 37'd32768) >> 16);
    cf_w    = 27'((f_q + 43'd32768) >> 16);
    sp_sel  = lim_q ? 48'({cfg_i.continuous_torque_limit, 16'h0000}) : sp_q;
    sp_w    = 33'((sp_sel + 48'd32768) >> 16);
    cur_cap = lim_q ? cfg_i.continuous_current_limit : cfg_i.stall_current_limit;
    res.elbow_torque  = et_w[20] ? '1 : et_w[19:0];
    res.cable_force   = cf_w[26] ? '1 : cf_w[25:0];
    res.spool_torque  = (sp_w > 33'h0_000F_FFFF) ? '1 : sp_w[19:0];
    res.motor_current = (cur_q > NW'(cur_cap)) ? cur_cap : cur_q[15:0];
  end

  assign q_pop_o  = (st_q == ST_IDLE) && q_valid_i;
  assign load_out = (st_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      cnt_q <= '0;
      lim_q <= 1'b0;
    end else begin
      case (st_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            cnt_q <= '0;
            st_q  <= ST_CORDIC;
          end
        end
        ST_CORDIC: begin
          if (cnt_q == CNT_W'(SINE_STAGES - 1)) st_q <= ST_MUL_WG;
          else cnt_q <= cnt_q + 1'b1;
        end
        ST_MUL_WG: st_q <= ST_MUL_P;
        ST_MUL_P:  st_q <= ST_MUL_PS;
        ST_MUL_PS: st_q <= ST_MUL_T;
        ST_MUL_T:  st_q <= ST_F_GO;
        ST_F_GO:   st_q <= ST_F_WAIT;
        ST_F_WAIT: if (!div_busy) st_q <= ST_MUL_FS;
        ST_MUL_FS: st_q <= ST_S_GO;
        ST_S_GO:   st_q <= ST_S_WAIT;
        ST_S_WAIT: if (!div_busy) st_q <= ST_C_DEC;
        ST_C_DEC: begin
          lim_q <= lim_now;
          st_q  <= (kt == 16'h0000) ? ST_OUT : ST_C_GO;
        end
        ST_C_GO:   st_q <= ST_C_WAIT;
        ST_C_WAIT: if (!div_busy) st_q <= ST_OUT;
        ST_OUT:    if (load_out) st_q <= ST_IDLE;
        default:   st_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: begin
        w_q <= q_item_i.load_weight;
        a_q <= q_item_i.assist_share;
        z_q <= q_item_i.angle;
        x_q <= eacs_pkg::CORDIC_GAIN_Q30;
        y_q <= '0;
      end
      ST_CORDIC: begin
        if (!z_q[31]) begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - at;
        end else begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + at;
        end
      end
      ST_MUL_WG: acc_q <= 52'(prod_wg);
      ST_MUL_P:  acc_q <= 52'((prod_p + 52'd524288) >> 20);
      ST_MUL_PS: acc_q <= 52'((prod_s + 63'd33554432) >> 26);
      ST_MUL_T:  t_q   <= 37'((prod_t + 53'd16384) >> 15);
      ST_F_WAIT: if (!div_busy) f_q <= div_quo[42:0];
      ST_MUL_FS: acc_q <= 52'((prod_f + 59'd32768) >> 16);
      ST_S_WAIT: if (!div_busy) sp_q <= div_quo[47:0];
      ST_C_DEC: begin
        if (lim_now) cur_q <= NW'(cfg_i.continuous_current_limit);
        else         cur_q <= '0;
      end
      ST_C_WAIT: if (!div_busy) cur_q <= div_quo;
      default: ;
    endcase
  end

  // Result register, decouples the engine from the output stall
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `EACS_ASSERT_IMP(a_pop_idle, clk_i, rst_ni, q_pop_o, st_q == ST_IDLE, "job popped while busy")
  `EACS_ASSERT_IMP(a_div_go, clk_i, rst_ni, div_go, !div_busy, "divider restarted while busy")
  `EACS_ASSERT_IMP(a_cordic_cnt, clk_i, rst_ni, st_q == ST_CORDIC, cnt_q <= CNT_W'(SINE_STAGES - 1), "CORDIC step overrun")

endmodule

// File: hdl/elbow_assist_current_setpoint_core.sv
// Elbow assist current setpoint: one result transaction per input transaction,
// in order. The back end takes one item at a time: a pop from the queue,
// SINE_STAGES CORDIC rotations, five multiply steps, up to three divisions on
// the one shared bit-serial divider, which sets the rate (the third is skipped
// when the torque constant is zero), and an output step. A two-entry queue in
// the front and a result register let input and output stall independently of
// the engine.
module elbow_assist_current_setpoint_core #(
  parameter int SINE_STAGES = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  eacs_pkg::in_item_t                    in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output eacs_pkg::out_item_t                   out_data_o,
  input  logic                                  cfg_we_i,
  input  logic [eacs_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [eacs_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  eacs_pkg::cfg_t cfg_q;
  logic           q_valid, q_pop;
  eacs_pkg::job_t q_item;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hand_radius              <= eacs_pkg::RST_HAND_RADIUS;
      cfg_q.elbow_moment_arm         <= eacs_pkg::RST_ELBOW_ARM;
      cfg_q.spool_radius             <= eacs_pkg::RST_SPOOL_RADIUS;
      cfg_q.drive_efficiency         <= eacs_pkg::RST_DRIVE_EFF;
      cfg_q.torque_constant          <= eacs_pkg::RST_TORQUE_CONST;
      cfg_q.continuous_torque_limit  <= eacs_pkg::RST_CONT_TORQUE;
      cfg_q.continuous_current_limit <= eacs_pkg::RST_CONT_CURRENT;
      cfg_q.stall_current_limit      <= eacs_pkg::RST_STALL_CURRENT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        eacs_pkg::CFG_HAND_RADIUS:   cfg_q.hand_radius      <= cfg_data_i[15:0];
        eacs_pkg::CFG_ELBOW_ARM:     cfg_q.elbow_moment_arm <= cfg_data_i[15:0];
        eacs_pkg::CFG_SPOOL_RADIUS:  cfg_q.spool_radius     <= cfg_data_i[15:0];
        eacs_pkg::CFG_DRIVE_EFF:     cfg_q.drive_efficiency <= cfg_data_i[15:0];
        eacs_pkg::CFG_TORQUE_CONST:  cfg_q.torque_constant  <= cfg_data_i[15:0];
        eacs_pkg::CFG_CONT_TORQUE:   cfg_q.continuous_torque_limit  <= cfg_data_i;
        eacs_pkg::CFG_CONT_CURRENT:  cfg_q.continuous_current_limit <= cfg_data_i[15:0];
        eacs_pkg::CFG_STALL_CURRENT: cfg_q.stall_current_limit      <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  eacs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_item_o   (q_item)
  );

  eacs_back #(
    .SINE_STAGES (SINE_STAGES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .cfg_i       (cfg_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
